FILE: design/spq_pkg.sv
// Shared types and constants of the stable priority queue.
package spq_pkg;

  localparam int SPQ_DEPTH_DEF = 16;
  localparam int PRI_W         = 2;
  localparam int ARR_W         = 16;
  localparam int KEY_W         = 16;
  localparam int OCC_W         = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_SERVE    = 2'd1,
    FUNC_WITHDRAW = 2'd2,
    FUNC_TRANSFER = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NOMATCH = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_mode_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [PRI_W-1:0] new_priority;
    logic [ARR_W-1:0] arrival_number;
    logic [KEY_W-1:0] match_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PRI_W-1:0] removed_priority;
    logic [ARR_W-1:0] removed_arrival;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [PRI_W-1:0] new_priority;
    logic [ARR_W-1:0] new_arrival;
  } cell_ctrl_t;

endpackage

FILE: design/stable_priority_queue.sv
// Top level of the stable priority queue: request control, cell row and result register.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_item  (in_item_t)
//   out_     output     out_valid/out_stall out_item (out_item_t)
//
// For each request, the transfer edge latches every cell's match flag, and the edge on
// which the request executes applies insert or removal across the row in one shift.
// The first matching slot is found by a prefix chain running through the cells.
// A held result delays the shift until the output register is free.
// rst_n is synchronous; reset empties the queue and clears the control state.
module stable_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = SPQ_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  in_item_t         req_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        res;
  cell_ctrl_t       ctrl;
  logic             accept, go, full, empty, found;

  logic [QUEUE_DEPTH-1:0] occ, seen_w, first_w;
  logic [PRI_W-1:0]       pri_w [QUEUE_DEPTH];
  logic [ARR_W-1:0]       arr_w [QUEUE_DEPTH];
  logic [PRI_W-1:0]       rem_pri;
  logic [ARR_W-1:0]       rem_arr;

  assign in_stall = (state_r == S_EXEC);
  assign accept   = in_valid && !in_stall;
  assign go       = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign found    = seen_w[QUEUE_DEPTH-1];

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic             prev;
      logic [PRI_W-1:0] lp, rp;
      logic [ARR_W-1:0] la, ra;

      assign occ[gi] = (count_r > CW'(gi));

      if (gi == 0) begin : g_head
        assign prev = 1'b0;
        assign lp   = pri_w[gi];
        assign la   = arr_w[gi];
      end else begin : g_body
        assign prev = seen_w[gi-1];
        assign lp   = pri_w[gi-1];
        assign la   = arr_w[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign rp = pri_w[gi];
        assign ra = arr_w[gi];
      end else begin : g_next
        assign rp = pri_w[gi+1];
        assign ra = arr_w[gi+1];
      end

      spq_cell #(
        .IS_HEAD (gi == 0)
      ) u_cell (
        .clk       (clk),
        .in_load   (accept),
        .in_item   (in_item),
        .occ       (occ[gi]),
        .ctrl      (ctrl),
        .prev_seen (prev),
        .seen      (seen_w[gi]),
        .first     (first_w[gi]),
        .left_pri  (lp),
        .left_arr  (la),
        .right_pri (rp),
        .right_arr (ra),
        .pri       (pri_w[gi]),
        .arr       (arr_w[gi])
      );
    end
  endgenerate

  always_comb begin
    rem_pri = '0;
    rem_arr = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rem_pri = rem_pri | (first_w[i] ? pri_w[i] : '0);
      rem_arr = rem_arr | (first_w[i] ? arr_w[i] : '0);
    end
  end

  always_comb begin
    ctrl.mode         = CELL_HOLD;
    ctrl.new_priority = req_r.new_priority;
    ctrl.new_arrival  = req_r.arrival_number;
    count_nxt         = count_r;
    res.status           = STAT_DONE;
    res.removed_priority = '0;
    res.removed_arrival  = '0;
    if (req_r.func == FUNC_INSERT) begin
      if (full) begin
        res.status = STAT_FULL;
      end else begin
        ctrl.mode = go ? CELL_INSERT : CELL_HOLD;
        count_nxt = count_r + 1'b1;
      end
    end else if (empty) begin
      res.status = STAT_EMPTY;
    end else if (found) begin
      ctrl.mode            = go ? CELL_REMOVE : CELL_HOLD;
      count_nxt            = count_r - 1'b1;
      res.removed_priority = rem_pri;
      res.removed_arrival  = rem_arr;
    end else begin
      res.status = STAT_NOMATCH;
    end
    res.occupancy = OCC_W'(count_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_item;
    if (go) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_one_first: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_w))
    else $error("more than one first match in the cell row");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    go && (req_r.func == FUNC_INSERT) && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not advance occupancy");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result raised without an executed request");

endmodule

FILE: design/spq_cell.sv
// One queue slot: holds an entry, flags it against a request, shifts with its neighbours.
module spq_cell import spq_pkg::*; #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic             clk,
  input  logic             in_load,
  input  in_item_t         in_item,
  input  logic             occ,
  input  cell_ctrl_t       ctrl,
  input  logic             prev_seen,
  output logic             seen,
  output logic             first,
  input  logic [PRI_W-1:0] left_pri,
  input  logic [ARR_W-1:0] left_arr,
  input  logic [PRI_W-1:0] right_pri,
  input  logic [ARR_W-1:0] right_arr,
  output logic [PRI_W-1:0] pri,
  output logic [ARR_W-1:0] arr
);

  logic [PRI_W-1:0] pri_r, pri_nxt;
  logic [ARR_W-1:0] arr_r, arr_nxt;
  logic             flag_r, flag_nxt;

  always_comb begin
    case (in_item.func)
      FUNC_INSERT:   flag_nxt = !(occ && (arr_r < in_item.arrival_number) &&
                                  (pri_r <= in_item.new_priority));
      FUNC_SERVE:    flag_nxt = IS_HEAD;
      FUNC_WITHDRAW: flag_nxt = occ && (arr_r == in_item.match_key);
      default:       flag_nxt = occ &&
                                ({{(KEY_W-PRI_W){1'b0}}, pri_r} == in_item.match_key);
    endcase
  end

  assign seen  = prev_seen | flag_r;
  assign first = flag_r & ~prev_seen;

  always_comb begin
    pri_nxt = pri_r;
    arr_nxt = arr_r;
    case (ctrl.mode)
      CELL_INSERT: begin
        if (first) begin
          pri_nxt = ctrl.new_priority;
          arr_nxt = ctrl.new_arrival;
        end else if (prev_seen) begin
          pri_nxt = left_pri;
          arr_nxt = left_arr;
        end
      end
      CELL_REMOVE: begin
        if (seen) begin
          pri_nxt = right_pri;
          arr_nxt = right_arr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_load) flag_r <= flag_nxt;
    pri_r <= pri_nxt;
    arr_r <= arr_nxt;
  end

  assign pri = pri_r;
  assign arr = arr_r;

endmodule
